// File: rtl/point_charge_potential_grid_top_assert.svh
// assertion macros for the potential grid block
`ifndef POINT_CHARGE_POTENTIAL_GRID_TOP_ASSERT_SVH
`define POINT_CHARGE_POTENTIAL_GRID_TOP_ASSERT_SVH
// same-cycle implication
`define PCPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PCPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/pcpg_pkg.sv
// types and constants of the potential grid block
package pcpg_pkg;
    localparam int POS_W   = 16;
    localparam int CHG_W   = 16;
    localparam int PIX_W   = 9;
    localparam int D2_W    = 34;
    localparam int ROOT_W  = 17;
    localparam int NUM_W   = 30;
    localparam int SUM_W   = 38;
    localparam int POT_W   = 32;
    localparam int HUE_W   = 9;
    localparam int GAIN_W  = 10;
    localparam int CFG_W   = 10;
    localparam int HUE_MAX = 360;

    typedef enum logic [1:0] {
        REG_ACTIVE_COUNT = 2'd0,
        REG_HUE_BASE     = 2'd1,
        REG_HUE_GAIN     = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CHG_W-1:0] c;
    } t_charge;
endpackage

// File: rtl/pcpg_mem.sv
// charge store memory with registered read
module pcpg_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  pcpg_pkg::t_charge  i_wdata,
    input  logic [IDX_W-1:0]   i_raddr,
    output pcpg_pkg::t_charge  o_rdata
);
    import pcpg_pkg::*;

    t_charge r_mem [DEPTH];
    t_charge r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/pcpg_sqrt.sv
// bit-serial integer square root, two radicand bits per cycle
module pcpg_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pcpg_pkg::D2_W-1:0]  i_val,
    output logic [pcpg_pkg::ROOT_W-1:0] o_root,
    output logic                       o_done
);
    import pcpg_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic [D2_W-1:0]   r_val;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    assign rem_sh = {r_rem[REM_W-3:0], r_val[D2_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[D2_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

// File: rtl/pcpg_div.sv
// restoring divider, one quotient bit per cycle
module pcpg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pcpg_pkg::NUM_W-1:0]  i_num,
    input  logic [pcpg_pkg::ROOT_W-1:0] i_den,
    output logic [pcpg_pkg::NUM_W-1:0]  o_quo,
    output logic                        o_done
);
    import pcpg_pkg::*;

    localparam int REM_W = ROOT_W + 1;

    logic [NUM_W-1:0]  r_num;
    logic [ROOT_W-1:0] r_den;
    logic [REM_W-1:0]  r_rem;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  rem_sh;

    assign rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sh - {1'b0, r_den};
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;
endmodule

// File: rtl/point_charge_potential_grid_top.sv
// top level: charge store, sequencer, root and divide units, hue mapping
// a load writes the charge store when accepted; an evaluate processes each active charge in turn
// per charge: memory read, distance square, root, divide and add
// then saturate, hue multiply and output register, one evaluate at a time
// synchronous active-low reset clears control state and sets the configuration registers to defaults
module point_charge_potential_grid_top #(
    parameter int MAX_PARTICLES = 8,
    parameter int GRID_SIZE     = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [pcpg_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_operation,
    input  logic [2:0]                  i_slot,
    input  logic [15:0]                 i_charge_pos_x,
    input  logic [15:0]                 i_charge_pos_y,
    input  logic signed [15:0]          i_charge_value,
    input  logic [8:0]                  i_pixel_x,
    input  logic [8:0]                  i_pixel_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_potential,
    output logic [8:0]                  o_hue,
    output logic                        o_saturated
);
    import pcpg_pkg::*;

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int PMAX  = GRID_SIZE - 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_DIST = 8'b0000_0100,
        S_SQRT = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_SAT  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_HUE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [3:0]  r_active;
    logic [8:0]  r_base;
    logic [9:0]  r_gain;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_idx;
    logic [14:0] r_px;
    logic [14:0] r_py;
    logic signed [SUM_W-1:0] r_sum;
    logic        r_neg;
    logic [CHG_W-1:0] r_cm;
    logic signed [POT_W-1:0] r_pot;
    logic        r_sat;
    logic [POT_W-1:0] r_mag;
    logic [POT_W+GAIN_W-1:0] r_prod;
    logic        r_ovalid;
    logic signed [POT_W-1:0] r_opot;
    logic [HUE_W-1:0] r_ohue;
    logic        r_osat;

    logic              sq_start;
    logic              sq_done;
    logic              dv_start;
    logic              dv_done;
    logic [ROOT_W-1:0] sq_root;
    logic [NUM_W-1:0]  dv_quo;
    logic [ROOT_W-1:0] root_nz;

    t_charge mem_rd;
    t_charge mem_wr;
    logic    mem_we;
    logic [IDX_W+2:0] slot_ext;
    logic    in_acc;

    logic [6:0] ac7;
    logic [6:0] n7;
    logic [11:0] pxc;
    logic [11:0] pyc;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0] adx;
    logic [15:0] ady;
    logic [D2_W-1:0] d2;
    logic signed [CHG_W-1:0] cv;
    logic signed [SUM_W-1:0] term;
    logic signed [POT_W+GAIN_W+1:0] h;
    logic [27:0] ht;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    assign slot_ext = (IDX_W + 3)'(i_slot);
    assign mem_we   = in_acc && (t_op'(i_operation) == OP_LOAD)
                      && (int'(slot_ext) < MAX_PARTICLES);
    assign mem_wr   = '{x: i_charge_pos_x, y: i_charge_pos_y, c: i_charge_value};

    pcpg_mem #(.DEPTH(MAX_PARTICLES), .IDX_W(IDX_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (slot_ext[IDX_W-1:0]),
        .i_wdata (mem_wr),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rd)
    );

    pcpg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (d2),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    assign root_nz = (sq_root == '0) ? ROOT_W'(1) : sq_root;

    pcpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   ({r_cm, 14'd0}),
        .i_den   (root_nz),
        .o_quo   (dv_quo),
        .o_done  (dv_done)
    );

    assign ac7 = {3'd0, r_active};
    assign n7  = (ac7 > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES) : ac7;
    assign pxc = ({3'd0, i_pixel_x} > 12'(PMAX)) ? 12'(PMAX) : {3'd0, i_pixel_x};
    assign pyc = ({3'd0, i_pixel_y} > 12'(PMAX)) ? 12'(PMAX) : {3'd0, i_pixel_y};

    assign dx  = {2'b00, r_px} - {1'b0, mem_rd.x};
    assign dy  = {2'b00, r_py} - {1'b0, mem_rd.y};
    assign adx = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady = dy[16] ? 16'(-dy) : dy[15:0];
    assign d2  = D2_W'(32'(adx) * 32'(adx)) + D2_W'(32'(ady) * 32'(ady));
    assign cv  = mem_rd.c;

    assign term = r_neg ? -SUM_W'(signed'({1'b0, dv_quo})) : SUM_W'(signed'({1'b0, dv_quo}));

    assign sq_start = (r_state == S_DIST);
    assign dv_start = (r_state == S_SQRT) && sq_done;

    assign h  = signed'({1'b0, r_base, 16'd0, 9'd0} >> 9)
                - signed'({2'b00, r_prod});
    assign ht = h[POT_W+GAIN_W+1 -: 28];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 4'd0;
            r_base   <= 9'd200;
            r_gain   <= 10'd150;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ACTIVE_COUNT: r_active <= i_cfg_wdata[3:0];
                REG_HUE_BASE:     r_base   <= i_cfg_wdata[8:0];
                REG_HUE_GAIN:     r_gain   <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
        end else begin
            if ((r_state == S_HUE) && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (t_op'(i_operation) == OP_EVAL)) begin
                        r_n   <= n7[CNT_W-1:0];
                        r_idx <= '0;
                        r_state <= (n7 == 7'd0) ? S_SAT : S_READ;
                    end
                end
                S_READ: r_state <= S_DIST;
                S_DIST: r_state <= S_SQRT;
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (dv_done) begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_state <= (r_idx + CNT_W'(1) == r_n) ? S_SAT : S_READ;
                    end
                end
                S_SAT: r_state <= S_MUL;
                S_MUL: r_state <= S_HUE;
                S_HUE: begin
                    if (!r_ovalid || i_ready) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px  <= {pxc[8:0], 6'd0};
            r_py  <= {pyc[8:0], 6'd0};
            r_sum <= '0;
        end
        if (r_state == S_DIST) begin
            r_neg <= cv[CHG_W-1];
            r_cm  <= cv[CHG_W-1] ? CHG_W'(-cv) : cv;
        end
        if ((r_state == S_DIV) && dv_done) begin
            r_sum <= r_sum + term;
        end
        if (r_state == S_SAT) begin
            if (r_sum > SUM_W'(signed'(32'h7FFF_FFFF))) begin
                r_pot <= 32'sh7FFF_FFFF;
                r_sat <= 1'b1;
                r_mag <= 32'h7FFF_FFFF;
            end else if (r_sum < -SUM_W'(signed'({1'b0, 32'h8000_0000}))) begin
                r_pot <= 32'sh8000_0000;
                r_sat <= 1'b1;
                r_mag <= 32'h8000_0000;
            end else begin
                r_pot <= r_sum[POT_W-1:0];
                r_sat <= 1'b0;
                r_mag <= r_sum[SUM_W-1] ? POT_W'(-r_sum) : r_sum[POT_W-1:0];
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= (POT_W+GAIN_W)'(r_mag) * (POT_W+GAIN_W)'(r_gain);
        end
        if ((r_state == S_HUE) && (!r_ovalid || i_ready)) begin
            r_opot <= r_pot;
            r_osat <= r_sat;
            if (h <= 0) begin
                r_ohue <= '0;
            end else if (ht > 28'(HUE_MAX)) begin
                r_ohue <= HUE_W'(HUE_MAX);
            end else begin
                r_ohue <= ht[HUE_W-1:0];
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_potential = r_opot;
    assign o_hue       = r_ohue;
    assign o_saturated = r_osat;
endmodule

// File: rtl/pcpg_checker.sv
// port-level checker for the potential grid block, bound to the top level
`include "point_charge_potential_grid_top_assert.svh"
module pcpg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_operation,
    input logic signed [31:0] o_potential,
    input logic [8:0]         o_hue,
    input logic               o_saturated
);
    `PCPG_ASSERT_NOW(a_hue_range, o_valid, o_hue <= 9'd360)
    `PCPG_ASSERT_NOW(a_sat_extreme, o_valid && o_saturated,
        o_potential == 32'sh7FFF_FFFF || o_potential == 32'sh8000_0000)
    `PCPG_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_potential))
    `PCPG_ASSERT_NEXT(a_eval_busy, i_valid && o_ready && i_operation, !o_ready)
endmodule

bind point_charge_potential_grid_top pcpg_checker u_pcpg_checker (.*);

// File: verif/testbench.sv
// testbench for point_charge_potential_grid_top: directed table then random requests, checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import pcpg_pkg::*;

    localparam int       DRAIN_CYCLES = 600;
    localparam int       IDLE_LIMIT   = 20000;
    localparam int       NUM_SLOTS    = 8;
    localparam int       NUM_PHASES   = 10;
    localparam int       PHASE_ITEMS  = 100;
    localparam int       NEAR_OFS_MAX = 63;
    localparam int       HUE_BASE_TOP = 511;
    localparam int       HUE_GAIN_TOP = 1023;
    localparam int       COUNT_TOP    = 15;
    localparam int       PIX_TOP      = 511;
    localparam int       BURST_MAX    = 20;
    localparam int       GAP_MAX      = 15;
    localparam int       RESET_CYCLES = 3;
    localparam int       RESET_HUE    = 200;
    localparam int       RESET_GAIN   = 150;
    localparam int       ONE_CHARGE   = 256;
    localparam int       ROOT_BITS    = 17;
    localparam logic [1:0] REG_BAD    = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_op                     op;
        logic [2:0]              slot;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic signed [CHG_W-1:0] c;
        logic [PIX_W-1:0]        px;
        logic [PIX_W-1:0]        py;
    } t_req;

    typedef struct {
        logic signed [POT_W-1:0] pot;
        logic [HUE_W-1:0]        hue;
        logic                    sat;
    } t_pot_result;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [CFG_W-1:0] val;
        t_req        req;
        logic        known;
        t_pot_result res;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_operation;
    logic [2:0]              i_slot;
    logic [15:0]             i_charge_pos_x;
    logic [15:0]             i_charge_pos_y;
    logic signed [15:0]      i_charge_value;
    logic [8:0]              i_pixel_x;
    logic [8:0]              i_pixel_y;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [31:0]      o_potential;
    logic [8:0]              o_hue;
    logic                    o_saturated;

    point_charge_potential_grid_top u_dut (.*);

    // shadow state
    logic [POS_W-1:0]        pos_x_mem [NUM_SLOTS];
    logic [POS_W-1:0]        pos_y_mem [NUM_SLOTS];
    logic signed [CHG_W-1:0] charge_mem [NUM_SLOTS];
    logic [3:0]              count_reg;
    logic [HUE_W-1:0]        base_reg;
    logic [GAIN_W-1:0]       gain_reg;

    t_pot_result pot_q[$];
    t_row        table_q[$];
    int          err_cnt;
    int          idle_cnt;
    int          burst_left;
    int          rx_cyc;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = ROOT_BITS; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_pot_result field_at(logic [PIX_W-1:0] pxi, logic [PIX_W-1:0] pyi);
        t_pot_result r;
        longint px, py, dx, dy, dist_v, cv, cm, q, sum, mag, h;
        int n;
        px  = longint'(pxi) << 6;
        py  = longint'(pyi) << 6;
        n   = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            dx   = px - longint'(pos_x_mem[i]);
            dy   = py - longint'(pos_y_mem[i]);
            dist_v = root_floor(dx * dx + dy * dy);
            if (dist_v < 1) dist_v = 1;
            cv  = longint'(charge_mem[i]);
            cm  = (cv < 0) ? -cv : cv;
            q   = (cm << 14) / dist_v;
            sum = (cv < 0) ? sum - q : sum + q;
        end
        r.sat = 1'b0;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.sat = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.sat = 1'b1;
        end
        mag = (sum < 0) ? -sum : sum;
        h   = longint'(base_reg) * 65536 - longint'(gain_reg) * mag;
        if (h <= 0) r.hue = '0;
        else if ((h >>> 16) > HUE_MAX) r.hue = HUE_W'(HUE_MAX);
        else r.hue = HUE_W'(h >>> 16);
        r.pot = POT_W'(sum);
        return r;
    endfunction

    function automatic void write_shadow(logic [1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_ACTIVE_COUNT: count_reg = val[3:0];
            REG_HUE_BASE:     base_reg  = val[HUE_W-1:0];
            REG_HUE_GAIN:     gain_reg  = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pot_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(negedge i_clk);
        i_valid     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_W'(val);
        @(posedge i_clk);
        write_shadow(idx, CFG_W'(val));
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_request(t_req r, logic known, t_pot_result typed);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_operation    <= r.op;
        i_slot         <= r.slot;
        i_charge_pos_x <= r.x;
        i_charge_pos_y <= r.y;
        i_charge_value <= r.c;
        i_pixel_x      <= r.px;
        i_pixel_y      <= r.py;
        do @(posedge i_clk); while (!o_ready);
        if (r.op == OP_LOAD) begin
            pos_x_mem[r.slot]  = r.x;
            pos_y_mem[r.slot]  = r.y;
            charge_mem[r.slot] = r.c;
        end else begin
            pot_q.insert(pot_q.size(), known ? typed : field_at(r.px, r.py));
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(BURST_MAX, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(GAP_MAX)) @(negedge i_clk);
        end
    endtask

    function automatic t_req rand_req();
        t_req r;
        r.op   = ($urandom_range(9) < 3) ? OP_LOAD : OP_EVAL;
        r.slot = 3'($urandom_range(NUM_SLOTS - 1));
        if ($urandom_range(1)) begin
            r.x = POS_W'($urandom);
            r.y = POS_W'($urandom);
        end else begin
            r.x = {1'b0, 9'($urandom_range(PIX_TOP)), 6'($urandom_range(NEAR_OFS_MAX))};
            r.y = {1'b0, 9'($urandom_range(PIX_TOP)), 6'($urandom_range(NEAR_OFS_MAX))};
        end
        r.c  = CHG_W'($urandom);
        r.px = PIX_W'($urandom_range(PIX_TOP));
        r.py = PIX_W'($urandom_range(PIX_TOP));
        if ($urandom_range(9) == 0) r.px = $urandom_range(1) ? PIX_W'(PIX_TOP) : '0;
        if ($urandom_range(9) == 0) r.py = $urandom_range(1) ? PIX_W'(PIX_TOP) : '0;
        return r;
    endfunction

    function automatic void add_cfg(logic [1:0] idx, int val);
        t_row w;
        w.kind = ROW_CFG;
        w.idx  = idx;
        w.val  = CFG_W'(val);
        w.known = 1'b0;
        table_q.insert(table_q.size(), w);
    endfunction

    function automatic void add_item(t_op op, int slot, int x, int y, int c, int px, int py);
        t_row w;
        w.kind     = ROW_ITEM;
        w.req.op   = op;
        w.req.slot = 3'(slot);
        w.req.x    = POS_W'(x);
        w.req.y    = POS_W'(y);
        w.req.c    = CHG_W'(c);
        w.req.px   = PIX_W'(px);
        w.req.py   = PIX_W'(py);
        w.known    = 1'b0;
        table_q.insert(table_q.size(), w);
    endfunction

    function automatic void add_typed(int pot, int hue, logic sat);
        table_q[$].known   = 1'b1;
        table_q[$].res.pot = pot;
        table_q[$].res.hue = HUE_W'(hue);
        table_q[$].res.sat = sat;
    endfunction

    // receiver
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc / 256) % 3)
            0:       i_ready <= 1'b1;
            1:       i_ready <= $urandom_range(1);
            default: i_ready <= ($urandom_range(7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_pot_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pot_q.size() == 0) begin
                $error("result with none expected: potential %0d", o_potential);
                err_cnt++;
            end else begin
                e = pot_q.pop_front();
                if (o_potential !== e.pot) begin
                    $error("potential: expected %0d, got %0d", e.pot, o_potential);
                    err_cnt++;
                end
                if (o_hue !== e.hue) begin
                    $error("hue: expected %0d, got %0d", e.hue, o_hue);
                    err_cnt++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %0d, got %0d", e.sat, o_saturated);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        t_pot_result none;
        t_req        r;
        err_cnt        = 0;
        idle_cnt       = 0;
        rx_cyc         = 0;
        burst_left     = 1;
        none           = '{pot: '0, hue: '0, sat: 1'b0};
        count_reg      = '0;
        base_reg       = RESET_HUE;
        gain_reg       = RESET_GAIN;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_ACTIVE_COUNT;
        i_cfg_wdata    <= '0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_operation    <= OP_LOAD;
        i_slot         <= '0;
        i_charge_pos_x <= '0;
        i_charge_pos_y <= '0;
        i_charge_value <= '0;
        i_pixel_x      <= '0;
        i_pixel_y      <= '0;

        // nothing active after reset
        add_item(OP_EVAL, 5, 16'hFFFF, 16'h1234, -1, 5, 7);
        add_typed(0, RESET_HUE, 1'b0);
        // full positive charges on the origin, active count past the store size
        for (int s = 0; s < NUM_SLOTS; s++) add_item(OP_LOAD, s, 0, 0, 32767, s, PIX_TOP);
        add_cfg(REG_ACTIVE_COUNT, COUNT_TOP);
        add_item(OP_EVAL, 0, 0, 0, 0, 0, 0);
        add_typed(32'sh7FFFFFFF, 0, 1'b1);
        add_item(OP_EVAL, 0, 0, 0, 0, PIX_TOP, PIX_TOP);
        // most negative charge on the evaluated point
        add_cfg(REG_ACTIVE_COUNT, 1);
        add_item(OP_LOAD, 0, 0, 0, -32768, 0, 0);
        add_item(OP_EVAL, 7, 16'hFFFF, 16'hFFFF, 32767, 0, 0);
        add_typed(-536870912, 0, 1'b0);
        add_item(OP_LOAD, 0, 16'hFFFF, 16'hFFFF, ONE_CHARGE, 0, 0);
        add_item(OP_EVAL, 0, 0, 0, 0, PIX_TOP, PIX_TOP);
        add_item(OP_EVAL, 0, 0, 0, 0, 0, PIX_TOP);
        // hue base above the cap, zero gain
        add_cfg(REG_HUE_GAIN, 0);
        add_cfg(REG_HUE_BASE, HUE_BASE_TOP);
        add_cfg(REG_BAD, 0);
        add_cfg(REG_ACTIVE_COUNT, 0);
        add_item(OP_EVAL, 0, 0, 0, 0, 100, 200);
        add_typed(0, HUE_MAX, 1'b0);
        add_cfg(REG_HUE_BASE, 0);
        add_item(OP_EVAL, 0, 0, 0, 0, 0, 0);
        add_typed(0, 0, 1'b0);
        add_cfg(REG_HUE_GAIN, HUE_GAIN_TOP);
        add_cfg(REG_HUE_BASE, HUE_MAX);
        add_cfg(REG_ACTIVE_COUNT, NUM_SLOTS);
        add_item(OP_EVAL, 0, 0, 0, 0, 3, 3);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_q[k]) begin
            if (table_q[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(table_q[k].idx, int'(table_q[k].val));
            end else begin
                send_request(table_q[k].req, table_q[k].known, table_q[k].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case ($urandom_range(3))
                0:       write_reg(REG_ACTIVE_COUNT, 0);
                1:       write_reg(REG_ACTIVE_COUNT, NUM_SLOTS);
                2:       write_reg(REG_ACTIVE_COUNT, COUNT_TOP);
                default: write_reg(REG_ACTIVE_COUNT, $urandom_range(COUNT_TOP));
            endcase
            case ($urandom_range(3))
                0:       write_reg(REG_HUE_BASE, 0);
                1:       write_reg(REG_HUE_BASE, HUE_MAX);
                2:       write_reg(REG_HUE_BASE, HUE_BASE_TOP);
                default: write_reg(REG_HUE_BASE, $urandom_range(HUE_BASE_TOP));
            endcase
            case ($urandom_range(3))
                0:       write_reg(REG_HUE_GAIN, 0);
                1:       write_reg(REG_HUE_GAIN, 1);
                2:       write_reg(REG_HUE_GAIN, HUE_GAIN_TOP);
                default: write_reg(REG_HUE_GAIN, $urandom_range(HUE_GAIN_TOP));
            endcase
            if (p == 0) write_reg(REG_BAD, $urandom_range(HUE_GAIN_TOP));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = rand_req();
                send_request(r, 1'b0, none);
            end
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/pcpg_pkg.sv
rtl/pcpg_mem.sv
rtl/pcpg_sqrt.sv
rtl/pcpg_div.sv
rtl/point_charge_potential_grid_top.sv
rtl/pcpg_checker.sv
verif/testbench.sv
